// ===== rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps

package sha256_pkg;

    localparam int WORD_W   = 32;
    localparam int NUM_H    = 8;
    localparam int WIN_LEN  = 16;
    localparam int COUNT_W  = 61;
    localparam int FILL_W   = 6;
    localparam int ROUND_W  = 6;
    localparam int IDX_W    = 3;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
    localparam logic [FILL_W-1:0] FILL_LEN_START = 6'd56;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
    localparam logic [IDX_W-1:0] IDX_LAST = 3'd7;

    localparam logic [WORD_W-1:0] INIT_H [NUM_H] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [1:0] {
        SEL_MSG,
        SEL_PAD80,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic                shift;
        byte_sel_t           sel;
        logic                count;
        logic                load;
        logic                round;
        logic                update;
        logic                init;
        logic [IDX_W-1:0]    len_idx;
        logic [ROUND_W-1:0]  round_idx;
        logic [IDX_W-1:0]    out_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
    } dp_status_t;

endpackage

// ===== rtl/sha256_dp.sv =====
`timescale 1ns / 1ps

module sha256_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sha256_pkg::dp_cmd_t   cmd,
    input  logic [7:0]            msg_byte,
    output sha256_pkg::dp_status_t status,
    output logic [31:0]           digest_word
);
    import sha256_pkg::*;

    logic [WORD_W-1:0]  hash_reg [NUM_H];
    logic [WORD_W-1:0]  hash_next [NUM_H];
    logic [WORD_W-1:0]  wv_reg [NUM_H];
    logic [WORD_W-1:0]  wv_next [NUM_H];
    logic [WORD_W-1:0]  win_reg [WIN_LEN];
    logic [WORD_W-1:0]  win_next [WIN_LEN];
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    logic [63:0]        len_bits;
    logic [7:0]         byte_in;
    logic [WORD_W-1:0]  w_new, t1, t2;
    logic [WORD_W-1:0]  ssig0, ssig1, bsig0, bsig1, ch, mj;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int s);
        rotr = (v >> s) | (v << (WORD_W - s));
    endfunction

    assign len_bits = {count_reg, 3'b000};

    always_comb begin
        unique case (cmd.sel)
            SEL_MSG:   byte_in = msg_byte;
            SEL_PAD80: byte_in = PAD_BYTE;
            SEL_ZERO:  byte_in = 8'h00;
            SEL_LEN:   byte_in = len_bits[{~cmd.len_idx, 3'b000} +: 8];
            default:   byte_in = 8'h00;
        endcase
    end

    always_comb begin
        ssig0 = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
        ssig1 = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
        w_new = win_reg[0] + ssig0 + win_reg[9] + ssig1;
        bsig1 = rotr(wv_reg[4], 6) ^ rotr(wv_reg[4], 11) ^ rotr(wv_reg[4], 25);
        ch    = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        t1    = wv_reg[7] + bsig1 + ch + ROUND_K[cmd.round_idx] + win_reg[0];
        bsig0 = rotr(wv_reg[0], 2) ^ rotr(wv_reg[0], 13) ^ rotr(wv_reg[0], 22);
        mj    = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
        t2    = bsig0 + mj;
    end

    always_comb begin
        hash_next  = hash_reg;
        wv_next    = wv_reg;
        win_next   = win_reg;
        count_next = count_reg;
        fill_next  = fill_reg;
        if (cmd.shift) begin
            for (int k = 0; k < WIN_LEN - 1; k++) begin
                win_next[k] = {win_reg[k][23:0], win_reg[k+1][31:24]};
            end
            win_next[WIN_LEN-1] = {win_reg[WIN_LEN-1][23:0], byte_in};
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.count) begin
            count_next = count_reg + 61'd1;
        end
        if (cmd.load) begin
            wv_next = hash_reg;
        end
        if (cmd.round) begin
            for (int k = 0; k < WIN_LEN - 1; k++) begin
                win_next[k] = win_reg[k+1];
            end
            win_next[WIN_LEN-1] = w_new;
            wv_next[7] = wv_reg[6];
            wv_next[6] = wv_reg[5];
            wv_next[5] = wv_reg[4];
            wv_next[4] = wv_reg[3] + t1;
            wv_next[3] = wv_reg[2];
            wv_next[2] = wv_reg[1];
            wv_next[1] = wv_reg[0];
            wv_next[0] = t1 + t2;
        end
        if (cmd.update) begin
            for (int k = 0; k < NUM_H; k++) begin
                hash_next[k] = hash_reg[k] + wv_reg[k];
            end
        end
        if (cmd.init) begin
            hash_next  = INIT_H;
            count_next = '0;
            fill_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg  <= INIT_H;
            count_reg <= '0;
            fill_reg  <= '0;
        end else begin
            hash_reg  <= hash_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        wv_reg  <= wv_next;
        win_reg <= win_next;
    end

    assign status.fill = fill_reg;
    assign digest_word = hash_reg[cmd.out_idx];

endmodule

// ===== rtl/sha256_ctrl.sv =====
`timescale 1ns / 1ps

module sha256_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   byte_present,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic                   m_tlast,
    output sha256_pkg::dp_cmd_t    cmd,
    input  sha256_pkg::dp_status_t status
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_PADLEN,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    state_t              resume_reg, resume_next;
    logic [ROUND_W-1:0]  round_reg, round_next;
    logic [IDX_W-1:0]    len_reg, len_next;
    logic [IDX_W-1:0]    out_reg, out_next;
    logic                block_full;

    assign block_full = (status.fill == FILL_LAST);

    always_comb begin
        state_next  = state_reg;
        resume_next = resume_reg;
        round_next  = round_reg;
        len_next    = len_reg;
        out_next    = out_reg;
        cmd           = '0;
        cmd.sel       = SEL_MSG;
        cmd.len_idx   = len_reg;
        cmd.round_idx = round_reg;
        cmd.out_idx   = out_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.shift = byte_present;
                    cmd.count = byte_present;
                    if (byte_present && block_full) begin
                        state_next  = ST_LOAD;
                        resume_next = s_tlast ? ST_PAD80 : ST_IDLE;
                    end else if (s_tlast) begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                cmd.shift = 1'b1;
                cmd.sel   = SEL_PAD80;
                if (block_full) begin
                    state_next  = ST_LOAD;
                    resume_next = ST_PADZ;
                end else begin
                    state_next = ST_PADZ;
                end
            end
            ST_PADZ: begin
                if (status.fill == FILL_LEN_START) begin
                    state_next = ST_PADLEN;
                    len_next   = '0;
                end else begin
                    cmd.shift = 1'b1;
                    cmd.sel   = SEL_ZERO;
                    if (block_full) begin
                        state_next  = ST_LOAD;
                        resume_next = ST_PADZ;
                    end
                end
            end
            ST_PADLEN: begin
                cmd.shift = 1'b1;
                cmd.sel   = SEL_LEN;
                len_next  = len_reg + 3'd1;
                if (len_reg == IDX_LAST) begin
                    state_next  = ST_LOAD;
                    resume_next = ST_OUT;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                round_next = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                out_next   = '0;
                state_next = resume_reg;
            end
            ST_OUT: begin
                if (m_tready) begin
                    out_next = out_reg + 3'd1;
                    if (out_reg == IDX_LAST) begin
                        cmd.init   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            resume_reg <= ST_IDLE;
            round_reg  <= '0;
            len_reg    <= '0;
            out_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            round_reg  <= round_next;
            len_reg    <= len_next;
            out_reg    <= out_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = (out_reg == IDX_LAST);

endmodule

// ===== rtl/sha256_message_hasher_top.sv =====
`timescale 1ns / 1ps

// SHA-256 hasher. Feed the message one byte per word: tdata carries the byte,
// tuser[0] says a byte is present, and tlast closes the message (a word with
// tuser[0] low and tlast high closes it without a byte, so the empty message
// works). A byte word is taken whenever the input is ready; every 64th byte stalls the
// input for a compression (load, 64 rounds of one round per cycle, hash update).
// Closing a message pads the block (0x80, then zeros: up to 64 bytes, plus 8 for
// the length), runs one or two more compressions, then emits the eight digest
// words H0 first with the index on tuser and tlast on H7.
// The input is held off until the last digest word is taken.

module sha256_message_hasher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] byte_present
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_number
    output logic        m_tlast
);
    import sha256_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sha256_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .byte_present (s_tuser[0]),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tlast      (m_tlast),
        .cmd          (cmd),
        .status       (status)
    );

    sha256_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .msg_byte    (s_tdata),
        .status      (status),
        .digest_word (m_tdata)
    );

    assign m_tuser = cmd.out_idx;

endmodule

// ===== test/sha256_message_hasher_top_test.sv =====
`timescale 1ns / 1ps

module sha256_message_hasher_top_test;

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 300;

    class digest_scoreboard;
        typedef struct packed {
            logic [31:0] word;
            logic [2:0]  index;
            logic        last;
        } digest_entry_t;

        bit [31:0]     round_const [64];
        bit [31:0]     chain [8];
        bit [7:0]      msg_block [64];
        bit [60:0]     msg_bytes;
        digest_entry_t expected_digest_q [$];
        int            errors;
        int            messages;
        int            bytes_hashed;
        int            items;
        int            words_checked;

        function new();
            round_const = '{
                32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
                32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
                32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
                32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
                32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
                32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
                32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
                32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
                32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
                32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
                32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
                32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
                32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
            };
            foreach (msg_block[i]) msg_block[i] = 8'h00;
            errors = 0;
            messages = 0;
            bytes_hashed = 0;
            items = 0;
            words_checked = 0;
            restart_chain();
        endfunction

        function void restart_chain();
            chain = '{
                32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
            };
            msg_bytes = '0;
        endfunction

        function bit [31:0] rotr(bit [31:0] v, int s);
            return (v >> s) | (v << (32 - s));
        endfunction

        function void compress();
            bit [31:0] w [64];
            bit [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2;
            int        i;
            for (i = 0; i < 16; i++) begin
                w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
            end
            for (i = 16; i < 64; i++) begin
                w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                     + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
            end
            va = chain[0]; vb = chain[1]; vc = chain[2]; vd = chain[3];
            ve = chain[4]; vf = chain[5]; vg = chain[6]; vh = chain[7];
            for (i = 0; i < 64; i++) begin
                t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25))
                   + ((ve & vf) ^ (~ve & vg)) + round_const[i] + w[i];
                t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22))
                   + ((va & vb) ^ (va & vc) ^ (vb & vc));
                vh = vg; vg = vf; vf = ve; ve = vd + t1;
                vd = vc; vc = vb; vb = va; va = t1 + t2;
            end
            chain[0] += va; chain[1] += vb; chain[2] += vc; chain[3] += vd;
            chain[4] += ve; chain[5] += vf; chain[6] += vg; chain[7] += vh;
        endfunction

        function void note_word(bit [7:0] data, bit present, bit ends);
            int            fill;
            bit [63:0]     bit_len;
            digest_entry_t entry;
            if (present || ends) items++;
            if (present) begin
                msg_block[msg_bytes[5:0]] = data;
                msg_bytes = msg_bytes + 1'b1;
                bytes_hashed++;
                if (msg_bytes[5:0] == 6'd0) compress();
            end
            if (ends) begin
                fill = msg_bytes[5:0];
                msg_block[fill] = 8'h80;
                fill = fill + 1;
                if (fill > 56) begin
                    while (fill < 64) begin
                        msg_block[fill] = 8'h00;
                        fill = fill + 1;
                    end
                    compress();
                    fill = 0;
                end
                while (fill < 56) begin
                    msg_block[fill] = 8'h00;
                    fill = fill + 1;
                end
                bit_len = {msg_bytes, 3'b000};
                for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[63-8*i -: 8];
                compress();
                for (int i = 0; i < 8; i++) begin
                    entry.word  = chain[i];
                    entry.index = i[2:0];
                    entry.last  = (i[2:0] == sha256_pkg::IDX_LAST);
                    expected_digest_q = {expected_digest_q, entry};
                end
                messages++;
                restart_chain();
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_digest_word(logic [31:0] word, logic [2:0] index, logic last);
            digest_entry_t want;
            if (expected_digest_q.size() == 0) begin
                report_mismatch($sformatf("unexpected digest word %h index %0d", word, index));
            end else begin
                want = expected_digest_q.pop_front();
                words_checked++;
                if (word !== want.word)
                    report_mismatch($sformatf("digest word %h, want %h", word, want.word));
                if (index !== want.index)
                    report_mismatch($sformatf("word number %0d, want %0d", index, want.index));
                if (last !== want.last)
                    report_mismatch($sformatf("last flag %b on word %0d, want %b",
                                              last, want.index, want.last));
            end
        endtask

        function int pending();
            return expected_digest_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    digest_scoreboard sb = new();
    int               quiet_cycles = 0;
    int               burst_left = 0;
    int               ready_cycle = 0;
    int               ready_mode = 0;

    sha256_message_hasher_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_digest_word(m_tdata, m_tuser, m_tlast);
        if (aresetn && s_tvalid && s_tready) sb.note_word(s_tdata, s_tuser[0], s_tlast);
        if (aresetn && ((m_tvalid && m_tready) || (s_tvalid && s_tready))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: switch between always ready, random stalls, a fixed duty and long stalls
    always @(negedge aclk) begin
        ready_cycle <= ready_cycle + 1;
        if (ready_cycle % 50 == 0) ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 9) < 7);
            end
            2: begin
                m_tready <= (ready_cycle % 5 != 0);
            end
            default: begin
                m_tready <= (ready_cycle % 12 == 0);
            end
        endcase
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_word(logic [7:0] data, logic present, logic ends);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= present;
        s_tlast  <= ends;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
    endtask

    task automatic drain_digests();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    task automatic send_message(int len, bit bare_end);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_word(pick_byte(), 1'b0, 1'b0);
            send_word(pick_byte(), 1'b1, (i == len - 1) && !bare_end);
        end
        if (bare_end || len == 0) send_word(pick_byte(), 1'b0, 1'b1);
    endtask

    initial begin
        int len;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty message, "abc", idle word inside a message, single byte closing, empty again
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'ha5, 1'b0, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'hff, 1'b0, 1'b1);
        drain_digests();

        while (sb.items < 150) begin
            case ($urandom_range(0, 11))
                9:  len = $urandom_range(55, 56);
                10: len = $urandom_range(63, 64);
                11: len = $urandom_range(64, 130);
                default: len = $urandom_range(0, 24);
            endcase
            send_message(len, $urandom_range(0, 2) == 0);
            if ($urandom_range(0, 3) == 0) drain_digests();
        end

        drain_digests();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d digest words never arrived", sb.pending()));
        $display("hashed %0d messages (%0d bytes over %0d words), checked %0d digest words",
                 sb.messages, sb.bytes_hashed, sb.items, sb.words_checked);
        $display("lengths spanned empty, short and block-boundary messages; %0d mismatches",
                 sb.errors);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
